@@ src/gated_sine_duty_modulator_defines.svh @@
// Assertion macros shared by the modulator's modules.
// Each check is sampled on the rising edge of clk and is held off while rst_n is low.
`ifndef GATED_SINE_DUTY_MODULATOR_DEFINES_SVH
`define GATED_SINE_DUTY_MODULATOR_DEFINES_SVH

`ifndef SYNTHESIS

`define GSDM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

`define GSDM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define GSDM_ASSERT_IMPL(lbl, ante, cons)

`define GSDM_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ src/gsdm_pkg.sv @@
package gsdm_pkg;

  localparam int TableEntries = 256;
  localparam int DutyBits     = 10;
  localparam int IdxBits      = $clog2(TableEntries);
  localparam int PhaseBits    = 32;
  localparam int PhaseIdxLsb  = 16;
  localparam int SampleBits   = 16;
  localparam int MagBits      = SampleBits + 1;
  localparam int SumBits      = 48;
  localparam int CountBits    = 32;
  localparam int ThreshBits   = 16;
  localparam int ProdBits     = MagBits + CountBits;
  localparam int CfgDataBits  = 32;
  localparam int CfgIndexBits = 2;
  localparam int PwmMaxInt    = (1 << DutyBits) - 1;

  localparam logic [DutyBits-1:0]   PwmMax         = DutyBits'(PwmMaxInt);
  localparam logic [PhaseBits-1:0]  PhaseStepReset = 32'd838860;
  localparam logic [ThreshBits-1:0] ThreshReset    = 16'd30;
  localparam logic [DutyBits-1:0]   DutyLowReset   = DutyBits'((PwmMaxInt * 10) / 100);
  localparam logic [DutyBits-1:0]   DutyHighReset  = DutyBits'((PwmMaxInt * 90) / 100);

  localparam logic [CfgIndexBits-1:0] CfgPhaseStep = 2'd0;
  localparam logic [CfgIndexBits-1:0] CfgThreshold = 2'd1;
  localparam logic [CfgIndexBits-1:0] CfgDutyLow   = 2'd2;
  localparam logic [CfgIndexBits-1:0] CfgDutyHigh  = 2'd3;

  localparam logic MODE_TICK   = 1'b0;
  localparam logic KIND_DUTY   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TICK_ADV,
    S_TICK_ROM,
    S_TICK_MUL,
    S_TICK_FIN,
    S_SMP_ACC,
    S_SMP_MUL,
    S_SMP_FIN
  } ctrl_state_t;

  typedef struct packed {
    logic capture;
    logic phase_adv;
    logic rom_rd;
    logic mul_tick;
    logic mul_blk;
    logic acc;
    logic fin_tick;
    logic fin_blk;
  } dp_cmd_t;

  typedef struct packed {
    logic blk_end;
    logic out_free;
  } dp_sts_t;

  typedef logic [TableEntries-1:0][DutyBits-1:0] rom_t;

  // Sine table, built at elaboration from a fixed-point Taylor series in Q30.
  localparam logic [63:0] QOne      = 64'd1073741824;
  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;
  localparam logic [7:0][7:0] TaylorDiv = {8'd210, 8'd156, 8'd110, 8'd72,
                                           8'd42, 8'd20, 8'd6, 8'd1};

  function automatic logic [63:0] quarter_sine(input logic [63:0] a);
    logic [63:0] x;
    logic [63:0] term;
    logic [63:0] sum;
    x = (HalfPiQ30 * a) / TableEntries;
    term = x;
    sum = x;
    for (int k = 1; k <= 7; k++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      term = term / 64'(TaylorDiv[k[2:0]]);
      if (k[0]) begin
        sum = (sum > term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    return (sum > QOne) ? QOne : sum;
  endfunction

  function automatic rom_t build_rom();
    rom_t        rom;
    logic [63:0] n;
    logic [63:0] a;
    logic [63:0] s;
    logic [63:0] num;
    logic [63:0] v;
    logic        neg;
    n = 64'(TableEntries);
    for (int i = 0; i < TableEntries; i++) begin
      a = 64'(4 * i);
      neg = 1'b0;
      if (a >= 2 * n) begin
        neg = 1'b1;
        a = a - 2 * n;
      end
      if (a > n) begin
        a = 2 * n - a;
      end
      s = quarter_sine(a);
      num = neg ? (QOne - s) : (QOne + s);
      v = (num * 64'(PwmMaxInt) + QOne) >> 31;
      if (v > 64'(PwmMaxInt)) begin
        v = 64'(PwmMaxInt);
      end
      rom[i] = v[DutyBits-1:0];
    end
    return rom;
  endfunction

  localparam rom_t SineRom = build_rom();

endpackage

@@ src/gsdm_in_if.sv @@
interface gsdm_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  mode;
  logic signed [gsdm_pkg::SampleBits-1:0] pcm_sample;
  logic                                  block_end;

  modport source (output valid, output mode, output pcm_sample, output block_end,
                  input ready);
  modport sink (input valid, input mode, input pcm_sample, input block_end,
                output ready);
endinterface

@@ src/gsdm_out_if.sv @@
interface gsdm_out_if;
  logic                          valid;
  logic                          ready;
  logic                          result_kind;
  logic [gsdm_pkg::DutyBits-1:0] duty;
  logic                          audio_active;

  modport source (output valid, output result_kind, output duty, output audio_active,
                  input ready);
  modport sink (input valid, input result_kind, input duty, input audio_active,
                output ready);
endinterface

@@ src/gated_sine_duty_modulator.sv @@
// Channel  Direction  Payload                             Handshake
// in_ch    sink       mode, pcm_sample, block_end         valid / ready
// out_ch   source     result_kind, duty, audio_active     valid / ready
// cfg_*    sink       cfg_index, cfg_data                 cfg_wr_en, no back-pressure
//
// A tick passes through acceptance, phase add, table read, multiply, and divide and clamp,
// and its duty word is loaded in the divide and clamp step.
// A sample is accepted and accumulated; on a block end it goes on to a step forming
// (threshold + 1) times count for the mean test, then a step that loads the status word.
// in_ch.ready is high only while idle; a finishing step waits while out_ch holds a word.
// Synchronous reset clears the phase, flag and block sums and restores register defaults.
module gated_sine_duty_modulator (
  input  logic                                clk,
  input  logic                                rst_n,
  gsdm_in_if.sink                             in_ch,
  gsdm_out_if.source                          out_ch,
  input  logic                                cfg_wr_en,
  input  logic [gsdm_pkg::CfgIndexBits-1:0]   cfg_index,
  input  logic [gsdm_pkg::CfgDataBits-1:0]    cfg_data
);

  gsdm_pkg::dp_cmd_t cmd;
  gsdm_pkg::dp_sts_t sts;
  logic              in_ready;

  assign in_ch.ready = in_ready;

  gsdm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_mode  (in_ch.mode),
    .in_ready (in_ready),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  gsdm_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_pcm_sample    (in_ch.pcm_sample),
    .in_block_end     (in_ch.block_end),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_result_kind  (out_ch.result_kind),
    .out_duty         (out_ch.duty),
    .out_audio_active (out_ch.audio_active)
  );

endmodule

@@ src/gsdm_ctrl.sv @@
`include "gated_sine_duty_modulator_defines.svh"

module gsdm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_mode,
  output logic              in_ready,
  input  gsdm_pkg::dp_sts_t sts_i,
  output gsdm_pkg::dp_cmd_t cmd_o
);

  gsdm_pkg::ctrl_state_t state_r;
  gsdm_pkg::ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gsdm_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gsdm_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_mode == gsdm_pkg::MODE_TICK) ? gsdm_pkg::S_TICK_ADV
                                                       : gsdm_pkg::S_SMP_ACC;
        end
      end
      gsdm_pkg::S_TICK_ADV: state_nxt = gsdm_pkg::S_TICK_ROM;
      gsdm_pkg::S_TICK_ROM: state_nxt = gsdm_pkg::S_TICK_MUL;
      gsdm_pkg::S_TICK_MUL: state_nxt = gsdm_pkg::S_TICK_FIN;
      gsdm_pkg::S_TICK_FIN: begin
        if (sts_i.out_free) begin
          state_nxt = gsdm_pkg::S_IDLE;
        end
      end
      gsdm_pkg::S_SMP_ACC: begin
        state_nxt = sts_i.blk_end ? gsdm_pkg::S_SMP_MUL : gsdm_pkg::S_IDLE;
      end
      gsdm_pkg::S_SMP_MUL: state_nxt = gsdm_pkg::S_SMP_FIN;
      gsdm_pkg::S_SMP_FIN: begin
        if (sts_i.out_free) begin
          state_nxt = gsdm_pkg::S_IDLE;
        end
      end
      default: state_nxt = gsdm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o    = '0;
    in_ready = 1'b0;
    case (state_r)
      gsdm_pkg::S_IDLE: begin
        in_ready      = 1'b1;
        cmd_o.capture = in_valid;
      end
      gsdm_pkg::S_TICK_ADV: cmd_o.phase_adv = 1'b1;
      gsdm_pkg::S_TICK_ROM: cmd_o.rom_rd    = 1'b1;
      gsdm_pkg::S_TICK_MUL: cmd_o.mul_tick  = 1'b1;
      gsdm_pkg::S_TICK_FIN: cmd_o.fin_tick  = sts_i.out_free;
      gsdm_pkg::S_SMP_ACC:  cmd_o.acc       = 1'b1;
      gsdm_pkg::S_SMP_MUL:  cmd_o.mul_blk   = 1'b1;
      gsdm_pkg::S_SMP_FIN:  cmd_o.fin_blk   = sts_i.out_free;
      default: cmd_o = '0;
    endcase
  end

  `GSDM_ASSERT_IMPL(a_fin_needs_slot, cmd_o.fin_tick || cmd_o.fin_blk, sts_i.out_free)
  `GSDM_ASSERT_NEXT(a_tick_dispatch, state_r == gsdm_pkg::S_IDLE && in_valid && !in_mode, state_r == gsdm_pkg::S_TICK_ADV)
  `GSDM_ASSERT_NEXT(a_sample_no_result, state_r == gsdm_pkg::S_SMP_ACC && !sts_i.blk_end, state_r == gsdm_pkg::S_IDLE)

endmodule

@@ src/gsdm_dp.sv @@
`include "gated_sine_duty_modulator_defines.svh"

module gsdm_dp (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_wr_en,
  input  logic [gsdm_pkg::CfgIndexBits-1:0]       cfg_index,
  input  logic [gsdm_pkg::CfgDataBits-1:0]        cfg_data,
  input  logic signed [gsdm_pkg::SampleBits-1:0]  in_pcm_sample,
  input  logic                                    in_block_end,
  input  gsdm_pkg::dp_cmd_t                       cmd_i,
  output gsdm_pkg::dp_sts_t                       sts_o,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic                                    out_result_kind,
  output logic [gsdm_pkg::DutyBits-1:0]           out_duty,
  output logic                                    out_audio_active
);

  localparam int DB = gsdm_pkg::DutyBits;

  logic [gsdm_pkg::PhaseBits-1:0]  phase_step_r;
  logic [gsdm_pkg::ThreshBits-1:0] thresh_r;
  logic [DB-1:0]                   duty_low_r;
  logic [DB-1:0]                   duty_high_r;

  logic [gsdm_pkg::PhaseBits-1:0]  phase_r;
  logic                            flag_r;
  logic [gsdm_pkg::SumBits-1:0]    sum_r;
  logic [gsdm_pkg::CountBits-1:0]  count_r;

  logic signed [gsdm_pkg::SampleBits-1:0] sample_r;
  logic                                   blk_end_r;
  logic [DB-1:0]                          rom_q_r;
  logic [gsdm_pkg::ProdBits-1:0]          prod_r;
  logic [gsdm_pkg::ProdBits-1:0]          prod_nxt;

  logic          out_valid_r;
  logic          out_kind_r;
  logic [DB-1:0] out_duty_r;
  logic          out_active_r;

  logic [gsdm_pkg::MagBits-1:0]   sample_ext;
  logic [gsdm_pkg::MagBits-1:0]   mag;
  logic [DB-1:0]                  span;
  logic [gsdm_pkg::MagBits-1:0]   mul_a;
  logic [gsdm_pkg::CountBits-1:0] mul_b;
  logic [2*DB-1:0]                scaled;
  logic [DB-1:0]                  quo_lo;
  logic [DB:0]                    rem;
  logic [DB-1:0]                  quo;
  logic [DB:0]                    duty_act;
  logic [DB:0]                    duty_idle;
  logic [DB:0]                    duty_raw;
  logic [DB-1:0]                  duty_nxt;
  logic                           active_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r <= gsdm_pkg::PhaseStepReset;
      thresh_r     <= gsdm_pkg::ThreshReset;
      duty_low_r   <= gsdm_pkg::DutyLowReset;
      duty_high_r  <= gsdm_pkg::DutyHighReset;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        gsdm_pkg::CfgPhaseStep: phase_step_r <= cfg_data[gsdm_pkg::PhaseBits-1:0];
        gsdm_pkg::CfgThreshold: thresh_r     <= cfg_data[gsdm_pkg::ThreshBits-1:0];
        gsdm_pkg::CfgDutyLow:   duty_low_r   <= cfg_data[DB-1:0];
        gsdm_pkg::CfgDutyHigh:  duty_high_r  <= cfg_data[DB-1:0];
        default: ;
      endcase
    end
  end

  assign sample_ext = {sample_r[gsdm_pkg::SampleBits-1], sample_r};
  assign mag = sample_r[gsdm_pkg::SampleBits-1] ? (~sample_ext + 1'b1) : sample_ext;
  assign span = (duty_high_r >= duty_low_r) ? (duty_high_r - duty_low_r) : '0;

  // One multiplier serves both the duty scaling and the block mean test.
  assign mul_a = cmd_i.mul_blk ? ({1'b0, thresh_r} + 1'b1)
                               : gsdm_pkg::MagBits'(rom_q_r);
  assign mul_b = cmd_i.mul_blk ? count_r : gsdm_pkg::CountBits'(span);
  assign prod_nxt = gsdm_pkg::ProdBits'(mul_a) * gsdm_pkg::ProdBits'(mul_b);

  // Division by 2^DB - 1: the quotient estimate from a shift is at most one short.
  assign scaled = prod_r[2*DB-1:0];
  assign quo_lo = scaled[2*DB-1:DB];
  assign rem    = {1'b0, scaled[DB-1:0]} + {1'b0, quo_lo};
  assign quo    = (rem >= {1'b0, gsdm_pkg::PwmMax}) ? (quo_lo + 1'b1) : quo_lo;

  assign duty_act  = {1'b0, duty_low_r} + {1'b0, quo};
  assign duty_idle = ({1'b0, duty_low_r} + {1'b0, duty_high_r}) >> 1;
  assign duty_raw  = flag_r ? duty_act : duty_idle;

  always_comb begin
    if (duty_raw < {1'b0, duty_low_r}) begin
      duty_nxt = duty_low_r;
    end else if (duty_raw > {1'b0, duty_high_r}) begin
      duty_nxt = duty_high_r;
    end else begin
      duty_nxt = duty_raw[DB-1:0];
    end
  end

  // The truncated mean exceeds the threshold exactly when sum >= (threshold + 1) * count.
  assign active_nxt = (count_r != '0) && ({1'b0, sum_r} >= prod_r);

  always_ff @(posedge clk) begin
    if (cmd_i.capture) begin
      sample_r  <= in_pcm_sample;
      blk_end_r <= in_block_end;
    end
    if (cmd_i.rom_rd) begin
      rom_q_r <= gsdm_pkg::SineRom[phase_r[gsdm_pkg::PhaseIdxLsb +: gsdm_pkg::IdxBits]];
    end
    if (cmd_i.mul_tick || cmd_i.mul_blk) begin
      prod_r <= prod_nxt;
    end
    if (cmd_i.fin_tick) begin
      out_kind_r   <= gsdm_pkg::KIND_DUTY;
      out_duty_r   <= duty_nxt;
      out_active_r <= flag_r;
    end else if (cmd_i.fin_blk) begin
      out_kind_r   <= gsdm_pkg::KIND_STATUS;
      out_duty_r   <= '0;
      out_active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      flag_r      <= 1'b0;
      sum_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd_i.phase_adv) begin
        phase_r <= phase_r + phase_step_r;
      end
      if (cmd_i.acc && (count_r != '1)) begin
        sum_r   <= sum_r + gsdm_pkg::SumBits'(mag);
        count_r <= count_r + 1'b1;
      end else if (cmd_i.fin_blk) begin
        sum_r   <= '0;
        count_r <= '0;
      end
      if (cmd_i.fin_blk) begin
        flag_r <= active_nxt;
      end
      if (cmd_i.fin_tick || cmd_i.fin_blk) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts_o.blk_end  = blk_end_r;
  assign sts_o.out_free = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_result_kind  = out_kind_r;
  assign out_duty         = out_duty_r;
  assign out_audio_active = out_active_r;

  `GSDM_ASSERT_IMPL(a_empty_block_sum, count_r == '0, sum_r == '0)
  `GSDM_ASSERT_IMPL(a_status_duty_zero, out_valid_r && out_kind_r, out_duty_r == '0)

endmodule
